/* rtl/giou_pkg.sv */
// ----------------------------------------------------------------------------
// giou_pkg
// types and constants shared by the greedy iou suppression block
// ----------------------------------------------------------------------------
package giou_pkg;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 9;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IOU_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLASS_AWARE   = 1'd1;

   localparam logic [8:0] IOU_THRESHOLD_RESET = 9'd128;

   typedef struct packed {
      logic              frame_start;
      logic signed [15:0] box_x;
      logic signed [15:0] box_y;
      logic [15:0]       box_width;
      logic [15:0]       box_height;
      logic [6:0]        box_class;
   } req_type;

   typedef struct packed {
      logic       keep_box;
      logic [5:0] kept_index;
      logic       list_overflow;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] box_x;
      logic signed [15:0] box_y;
      logic [15:0]       box_width;
      logic [15:0]       box_height;
      logic [6:0]        box_class;
      logic [31:0]       area;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic read;
      logic write;
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic suppressed;
   } status_type;

endpackage

/* rtl/giou_datapath.sv */
// ----------------------------------------------------------------------------
// giou_datapath
// kept box memory, config registers and the pipelined iou compare
// ----------------------------------------------------------------------------
module giou_datapath #(
   parameter int MAX_KEPT = 64,
   parameter int IW       = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  giou_pkg::req_type                     req_data,
   input  giou_pkg::cmd_type                     cmd,
   input  logic [IW-1:0]                         rd_addr,
   input  logic [IW-1:0]                         wr_addr,
   input  logic                                  csr_write_enable,
   input  logic [giou_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [giou_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   output giou_pkg::status_type                  status
);
   import giou_pkg::*;

   function automatic logic [15:0] overlap(input logic signed [15:0] a0,
                                           input logic [15:0] al,
                                           input logic signed [15:0] b0,
                                           input logic [15:0] bl);
      logic signed [17:0] as, bs, ae, be, lo, hi, diff;
      as = {{2{a0[15]}}, a0};
      bs = {{2{b0[15]}}, b0};
      ae = as + $signed({2'b00, al});
      be = bs + $signed({2'b00, bl});
      lo = (as > bs) ? as : bs;
      hi = (ae < be) ? ae : be;
      diff = hi - lo;
      overlap = (hi > lo) ? diff[15:0] : 16'd0;
   endfunction

   entry_type mem [MAX_KEPT];

   logic [8:0]  thr_ff;
   logic        class_aware_ff;
   req_type     cur_ff;
   logic [31:0] area_ff;
   entry_type   rd_q_ff;

   logic        v0_ff, v1_ff, v2_ff, v3_ff;
   logic        elig1_ff, elig2_ff, elig3_ff;
   logic [15:0] iw_ff, ih_ff;
   logic [31:0] area1_ff, area2_ff;
   logic [31:0] inter2_ff, inter3_ff;
   logic [32:0] union3_ff;
   logic        suppressed_ff, suppressed_in;

   logic [15:0] iw_in, ih_in;
   logic [32:0] union_in;
   logic [39:0] lhs;
   logic [41:0] rhs;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff         <= IOU_THRESHOLD_RESET;
         class_aware_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IOU_THRESHOLD: thr_ff         <= csr_write_data;
            CSR_CLASS_AWARE:   class_aware_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_ff  <= req_data;
         area_ff <= 32'(req_data.box_width) * 32'(req_data.box_height);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[wr_addr] <= '{box_x: cur_ff.box_x, box_y: cur_ff.box_y,
                           box_width: cur_ff.box_width, box_height: cur_ff.box_height,
                           box_class: cur_ff.box_class, area: area_ff};
      end
      if (cmd.read) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   assign iw_in = overlap(cur_ff.box_x, cur_ff.box_width, rd_q_ff.box_x, rd_q_ff.box_width);
   assign ih_in = overlap(cur_ff.box_y, cur_ff.box_height, rd_q_ff.box_y, rd_q_ff.box_height);
   assign union_in = {1'b0, area_ff} + {1'b0, area2_ff} - {1'b0, inter2_ff};
   assign lhs = {inter3_ff, 8'd0};
   assign rhs = 42'(thr_ff) * 42'(union3_ff);

   always_ff @(posedge clock) begin
      iw_ff     <= iw_in;
      ih_ff     <= ih_in;
      elig1_ff  <= !class_aware_ff || (rd_q_ff.box_class == cur_ff.box_class);
      area1_ff  <= rd_q_ff.area;
      inter2_ff <= 32'(iw_ff) * 32'(ih_ff);
      area2_ff  <= area1_ff;
      elig2_ff  <= elig1_ff;
      inter3_ff <= inter2_ff;
      union3_ff <= union_in;
      elig3_ff  <= elig2_ff;
   end

   always_comb begin
      suppressed_in = suppressed_ff;
      priority if (cmd.load) begin
         suppressed_in = 1'b0;
      end else if (v3_ff && elig3_ff && ({2'b00, lhs} > rhs)) begin
         suppressed_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff         <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         suppressed_ff <= 1'b0;
      end else begin
         v0_ff         <= cmd.read;
         v1_ff         <= v0_ff;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         suppressed_ff <= suppressed_in;
      end
   end

   assign status.pipe_busy  = v0_ff | v1_ff | v2_ff | v3_ff;
   assign status.suppressed = suppressed_ff;

endmodule

/* rtl/giou_ctrl.sv */
// ----------------------------------------------------------------------------
// giou_ctrl
// sequencer: scans the kept list, waits for the pipe, issues the response
// ----------------------------------------------------------------------------
module giou_ctrl #(
   parameter int MAX_KEPT = 64,
   parameter int IW       = 6,
   parameter int CW       = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  frame_start,
   output logic                  busy,
   output giou_pkg::cmd_type     cmd,
   output logic [IW-1:0]         rd_addr,
   output logic [IW-1:0]         wr_addr,
   input  giou_pkg::status_type  status,
   output logic                  rsp_strobe,
   output giou_pkg::rsp_type     rsp_data
);
   import giou_pkg::*;

   state_type    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic          strobe_ff, strobe_in;
   rsp_type       rsp_ff, rsp_in;
   logic [CW+5:0] count_ext;
   logic          full;

   assign count_ext = {6'd0, count_ff};
   assign full      = (count_ff == CW'(MAX_KEPT));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         scan_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         scan_ff   <= scan_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      scan_in   = scan_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               scan_in  = '0;
               if (frame_start) begin
                  count_in = '0;
               end
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff < count_ff) begin
               cmd.read = 1'b1;
               scan_in  = scan_ff + CW'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            strobe_in = 1'b1;
            rsp_in    = '0;
            if (!status.suppressed) begin
               rsp_in.keep_box = 1'b1;
               if (full) begin
                  rsp_in.list_overflow = 1'b1;
               end else begin
                  cmd.write         = 1'b1;
                  rsp_in.kept_index = count_ext[5:0];
                  count_in          = count_ff + CW'(1);
               end
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rd_addr    = scan_ff[IW-1:0];
   assign wr_addr    = count_ff[IW-1:0];
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

/* rtl/greedy_iou_suppression.sv */
// ----------------------------------------------------------------------------
// greedy_iou_suppression
// greedy non-maximum suppression of score-sorted boxes against a kept list
//
//   channel   ports                                      handshake
//   request   start, busy, req_data                      start && !busy
//   response  rsp_strobe, rsp_data                       one-cycle strobe
//   csr       csr_write_enable, csr_index, csr_write_data single-cycle write
//
// a box is compared against every kept box, the pipe drains, then the response issues;
// the next box can be accepted in the response cycle
// one kept box is read per cycle and fed to a four-stage iou compare pipe
// synchronous active-high reset empties the kept list and restores the csrs
// the response cannot be held off; busy drops in the response cycle
// ----------------------------------------------------------------------------
module greedy_iou_suppression #(
   parameter int MAX_KEPT = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  giou_pkg::req_type                     req_data,
   output logic                                  rsp_strobe,
   output giou_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_write_enable,
   input  logic [giou_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [giou_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);
   import giou_pkg::*;

   localparam int IW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CW = $clog2(MAX_KEPT + 1);

   cmd_type       cmd;
   status_type    status;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] wr_addr;

   giou_ctrl #(
      .MAX_KEPT (MAX_KEPT),
      .IW       (IW),
      .CW       (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .frame_start (req_data.frame_start),
      .busy        (busy),
      .cmd         (cmd),
      .rd_addr     (rd_addr),
      .wr_addr     (wr_addr),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

   giou_datapath #(
      .MAX_KEPT (MAX_KEPT),
      .IW       (IW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .cmd              (cmd),
      .rd_addr          (rd_addr),
      .wr_addr          (wr_addr),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .status           (status)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   a_suppressed_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.keep_box) |->
         (rsp_data.kept_index == 6'd0 && !rsp_data.list_overflow))
      else $error("suppressed box carries index or overflow");

   a_overflow_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.list_overflow) |->
         (rsp_data.keep_box && rsp_data.kept_index == 6'd0))
      else $error("overflow response malformed");

endmodule

/* test/tb_greedy_iou_suppression.sv */
// ----------------------------------------------------------------------------
// tb_greedy_iou_suppression
// self-checking bench for the greedy iou suppression block
//
// boxes are sent through the start/busy command port. Each
// accepted transaction is run through an in-bench model of the kept list, and
// the verdict it gives is queued. Every response strobe is checked field by
// field against the oldest queued verdict. The bench opens with a short set of
// directed boxes, then sends clustered random frames under several threshold
// and class-aware settings. Long frames with no suppression fill the list
// until it overflows. The sender leaves random gaps and sometimes holds back
// until every verdict is in.
// ----------------------------------------------------------------------------
module tb_greedy_iou_suppression;
   timeunit 1ns;
   timeprecision 1ps;

   import giou_pkg::*;

   localparam int MAX_KEPT    = 64;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE      = 20;
   localparam int SPOTS       = 6;
   localparam int PHASES      = 8;
   localparam int PHASE_BOXES = 130;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data = '0;

   req_type box_queue[$];
   rsp_type verdict_queue[$];

   entry_type kept_list[MAX_KEPT];
   int kept_count = 0;
   logic [8:0] iou_threshold = IOU_THRESHOLD_RESET;
   logic iou_class_aware = 1'b0;

   logic item_taken = 1'b0;
   logic drain_first = 1'b0;
   int gap_left = 0;
   int calm_left = 0;
   int error_count = 0;
   int cycle_count = 0;

   int spot_x[SPOTS];
   int spot_y[SPOTS];
   int spot_w[SPOTS];
   int spot_h[SPOTS];

   greedy_iou_suppression #(
      .MAX_KEPT(MAX_KEPT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic longint span_overlap(input longint a0, input longint al,
                                           input longint b0, input longint bl);
      longint lo;
      longint hi;
      lo = (a0 > b0) ? a0 : b0;
      hi = (a0 + al < b0 + bl) ? a0 + al : b0 + bl;
      return (hi > lo) ? hi - lo : 0;
   endfunction

   function automatic rsp_type nms_verdict(input req_type box);
      rsp_type verdict;
      longint area;
      longint inter;
      longint uni;
      logic keep;
      keep = 1'b1;
      if (box.frame_start) kept_count = 0;
      area = longint'(box.box_width) * longint'(box.box_height);
      for (int i = 0; i < kept_count; i++) begin
         if (iou_class_aware && kept_list[i].box_class != box.box_class) continue;
         inter = span_overlap(box.box_x, box.box_width,
                              kept_list[i].box_x, kept_list[i].box_width)
               * span_overlap(box.box_y, box.box_height,
                              kept_list[i].box_y, kept_list[i].box_height);
         uni = area + longint'(kept_list[i].area) - inter;
         if (inter * 256 > longint'(iou_threshold) * uni) begin
            keep = 1'b0;
            break;
         end
      end
      verdict = '0;
      if (keep) begin
         verdict.keep_box = 1'b1;
         if (kept_count < MAX_KEPT) begin
            kept_list[kept_count].box_x = box.box_x;
            kept_list[kept_count].box_y = box.box_y;
            kept_list[kept_count].box_width = box.box_width;
            kept_list[kept_count].box_height = box.box_height;
            kept_list[kept_count].box_class = box.box_class;
            kept_list[kept_count].area = 32'(area);
            verdict.kept_index = 6'(kept_count);
            kept_count++;
         end else begin
            verdict.list_overflow = 1'b1;
         end
      end
      return verdict;
   endfunction

   function automatic int idle_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(99);
      if (r < 3) calm_left = $urandom_range(40, 120);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 8);
      if (r < 97) return $urandom_range(9, 80);
      return $urandom_range(81, 150);
   endfunction

   function automatic req_type random_box(input logic first);
      req_type b;
      int s;
      int jw;
      int jh;
      b.frame_start = first;
      if ($urandom_range(99) < 10) begin
         b.box_x = 16'($urandom);
         b.box_y = 16'($urandom);
         b.box_width = 16'($urandom);
         b.box_height = 16'($urandom);
         b.box_class = 7'($urandom);
      end else begin
         s = $urandom_range(SPOTS - 1);
         jw = spot_w[s] / 4 + 1;
         jh = spot_h[s] / 4 + 1;
         b.box_x = 16'(spot_x[s] + int'($urandom_range(jw)) - jw / 2);
         b.box_y = 16'(spot_y[s] + int'($urandom_range(jh)) - jh / 2);
         b.box_width = ($urandom_range(99) < 5) ? 16'd0 :
                       16'(spot_w[s] + int'($urandom_range(jw)) - jw / 2);
         b.box_height = ($urandom_range(99) < 5) ? 16'd0 :
                        16'(spot_h[s] + int'($urandom_range(jh)) - jh / 2);
         b.box_class = ($urandom_range(99) < 85) ? 7'($urandom_range(2)) :
                       7'($urandom_range(127));
      end
      return b;
   endfunction

   task automatic push_box(input logic fs, input logic signed [15:0] x,
                           input logic signed [15:0] y, input logic [15:0] w,
                           input logic [15:0] h, input logic [6:0] c);
      req_type b;
      b.frame_start = fs;
      b.box_x = x;
      b.box_y = y;
      b.box_width = w;
      b.box_height = h;
      b.box_class = c;
      box_queue = {box_queue, b};
   endtask

   task automatic queue_frames(input int count);
      int left;
      int frame_len;
      logic fs;
      left = count;
      while (left > 0) begin
         frame_len = ($urandom_range(99) < 8) ? $urandom_range(65, 72) : $urandom_range(1, 24);
         if (frame_len > left) frame_len = left;
         for (int s = 0; s < SPOTS; s++) begin
            spot_x[s] = int'($urandom_range(4000)) - 2000;
            spot_y[s] = int'($urandom_range(4000)) - 2000;
            spot_w[s] = $urandom_range(16, 1600);
            spot_h[s] = $urandom_range(16, 1600);
         end
         for (int k = 0; k < frame_len; k++) begin
            fs = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
            box_queue = {box_queue, random_box(fs)};
         end
         left -= frame_len;
      end
   endtask

   task automatic wait_idle();
      do begin
         @(negedge clock);
         #1;
      end while (box_queue.size() != 0 || start || busy || verdict_queue.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // driver: one transaction presented at a time, held until accepted
   always @(negedge clock) begin : drive
      int gap_next;
      logic launch;
      logic hold_next;
      req_type next_box;
      gap_next = gap_left;
      launch = start;
      hold_next = drain_first;
      next_box = req_data;
      if (!reset) begin
         if (start && item_taken) begin
            launch = 1'b0;
            gap_next = idle_gap();
            hold_next = ($urandom_range(99) < 3);
         end
         if (!launch) begin
            if (gap_next > 0) begin
               gap_next--;
            end else if (box_queue.size() != 0 && !(hold_next && verdict_queue.size() != 0)) begin
               next_box = box_queue.pop_front();
               launch = 1'b1;
               hold_next = 1'b0;
            end
         end
      end
      start <= launch;
      req_data <= next_box;
      gap_left <= gap_next;
      drain_first <= hold_next;
   end

   // monitor: csr writes, accepted transactions and response checks
   always @(posedge clock) begin : observe
      rsp_type want;
      if (reset) begin
         kept_count = 0;
         iou_threshold = IOU_THRESHOLD_RESET;
         iou_class_aware = 1'b0;
         item_taken <= 1'b0;
      end else begin
         item_taken <= start && !busy;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_IOU_THRESHOLD: iou_threshold = csr_write_data[8:0];
               CSR_CLASS_AWARE: iou_class_aware = csr_write_data[0];
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            if (verdict_queue.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response, expected none actual %p",
                        $time, rsp_data);
            end else begin
               want = verdict_queue.pop_front();
               if (rsp_data.keep_box !== want.keep_box) begin
                  error_count++;
                  $display("%0t: keep_box expected %0d actual %0d",
                           $time, want.keep_box, rsp_data.keep_box);
               end
               if (rsp_data.kept_index !== want.kept_index) begin
                  error_count++;
                  $display("%0t: kept_index expected %0d actual %0d",
                           $time, want.kept_index, rsp_data.kept_index);
               end
               if (rsp_data.list_overflow !== want.list_overflow) begin
                  error_count++;
                  $display("%0t: list_overflow expected %0d actual %0d",
                           $time, want.list_overflow, rsp_data.list_overflow);
               end
            end
         end
         if (start && !busy) verdict_queue = {verdict_queue, nms_verdict(req_data)};
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [8:0] thr_plan[PHASES];
      logic [8:0] aware_plan[PHASES];
      thr_plan = '{9'd128, 9'd0, 9'd256, 9'd511, 9'd64, 9'd200, 9'd0, 9'd128};
      aware_plan = '{9'h000, 9'h001, 9'h000, 9'h001, 9'h1FF, 9'h002, 9'h000, 9'h001};
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         if (p == 6) begin
            thr_plan[p] = 9'($urandom_range(511));
            aware_plan[p] = 9'($urandom);
         end
         wait_idle();
         write_csr(CSR_IOU_THRESHOLD, thr_plan[p]);
         write_csr(CSR_CLASS_AWARE, aware_plan[p]);
         if (p == 0) begin
            // extremes, touching and empty boxes
            push_box(1'b1, -16'sd32768, -16'sd32768, 16'hFFFF, 16'hFFFF, 7'd127);
            push_box(1'b0, -16'sd32768, -16'sd32768, 16'hFFFF, 16'hFFFF, 7'd127);
            push_box(1'b0, 16'sd32767, 16'sd32767, 16'd16, 16'd16, 7'd0);
            push_box(1'b0, 16'sd0, 16'sd0, 16'd0, 16'd0, 7'd5);
            push_box(1'b0, 16'sd0, 16'sd0, 16'd0, 16'd0, 7'd5);
            push_box(1'b0, 16'sd100, 16'sd100, 16'd0, 16'd500, 7'd5);
            // half-width shifts, touching edges and nesting under the default threshold
            push_box(1'b1, 16'sd0, 16'sd0, 16'd160, 16'd160, 7'd1);
            push_box(1'b0, 16'sd160, 16'sd0, 16'd160, 16'd160, 7'd1);
            push_box(1'b0, 16'sd0, 16'sd160, 16'd160, 16'd160, 7'd2);
            push_box(1'b0, 16'sd80, 16'sd0, 16'd160, 16'd160, 7'd1);
            push_box(1'b0, 16'sd1, 16'sd1, 16'd160, 16'd160, 7'd3);
            push_box(1'b0, -16'sd80, -16'sd80, 16'd320, 16'd320, 7'd1);
            push_box(1'b0, 16'sh5555, 16'shAAAA, 16'hAAAA, 16'h5555, 7'h2A);
            push_box(1'b0, 16'shAAAA, 16'sh5555, 16'h5555, 16'hAAAA, 7'h55);
            push_box(1'b1, 16'sd0, 16'sd0, 16'd16, 16'd16, 7'd0);
         end
         queue_frames(PHASE_BOXES);
      end

      wait_idle();
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* greedy_iou_suppression.f */
rtl/giou_pkg.sv
rtl/giou_datapath.sv
rtl/giou_ctrl.sv
rtl/greedy_iou_suppression.sv
test/tb_greedy_iou_suppression.sv
